// File: hw/rtl/sease_pkg.sv
// shared types, widths and the quarter-wave sine table for the sine easing block
// no dependencies; every module of the block imports this package
package sease_pkg;

   // sizing knobs
   localparam int TABLE_BITS = 8;
   localparam int TIME_BITS  = 16;

   // fixed field widths
   localparam int ELAPSED_W  = 16;
   localparam int DUR_W      = 16;
   localparam int VAL_W      = 16;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int MODE_W     = 2;
   localparam int RESULT_W   = 17;

   // phase in q0.16, one extra bit to hold exactly 1.0
   localparam int PHASE_FRAC = 16;
   localparam int PHASE_W    = PHASE_FRAC + 1;
   localparam int DIV_STEPS  = PHASE_FRAC;
   localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC;

   // table angle in q0.16 covering 0..2.0
   localparam int ANGLE_W    = PHASE_W + 1;
   localparam int ROM_SHIFT  = PHASE_FRAC - TABLE_BITS;
   localparam int ROM_N      = 1 << TABLE_BITS;
   localparam int IDX_W      = ANGLE_W - ROM_SHIFT;
   localparam int ADDR_W     = TABLE_BITS + 1;
   localparam int ROM_W      = 16;
   localparam logic [ANGLE_W-1:0] ANGLE_HALF_STEP = ANGLE_W'(1) << (ROM_SHIFT - 1);
   localparam logic [ANGLE_W-1:0] ANGLE_QUARTER   = ANGLE_W'(1) << PHASE_FRAC;

   // scaling product and rounding
   localparam int FACT_S_W   = PHASE_W + 1;
   localparam int PROD_W     = VAL_W + FACT_S_W;
   localparam int SUM_W      = PROD_W - PHASE_FRAC;

   // elapsed time is taken modulo 2^TIME_BITS
   localparam logic [ELAPSED_W-1:0] TIME_MASK = (TIME_BITS >= ELAPSED_W) ? '1 :
      ELAPSED_W'((64'd1 << TIME_BITS) - 64'd1);

   // register reset values
   localparam logic [DUR_W-1:0] DURATION_RESET = DUR_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DURATION = 2'd0,
      CSR_START    = 2'd1,
      CSR_CHANGE   = 2'd2,
      CSR_MODE     = 2'd3
   } csr_index_type;

   // mode three decodes as ease in/out through the default arm
   typedef enum logic [MODE_W-1:0] {
      CURVE_IN     = 2'd0,
      CURVE_OUT    = 2'd1,
      CURVE_IN_OUT = 2'd2
   } curve_mode_type;

   // control that travels with every beat in the pipeline
   typedef struct packed {
      logic valid;
      logic clamped;
   } beat_ctl_type;

   typedef logic [ROM_N:0][ROM_W-1:0] rom_type;

   // sin(k*pi/2/N) in q1.15: q2.30 angle, horner taylor series to x^13,
   // round half up, capped at 1.0
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] one;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] r;
      one = 64'd1 << 30;
      for (int k = 0; k <= ROM_N; k++) begin
         x  = (64'd1686629713 * 64'(k) + 64'(ROM_N / 2)) >> TABLE_BITS;
         x2 = (x * x) >> 30;
         t  = one;
         t  = one - ((x2 * t) >> 30) / 64'd156;
         t  = one - ((x2 * t) >> 30) / 64'd110;
         t  = one - ((x2 * t) >> 30) / 64'd72;
         t  = one - ((x2 * t) >> 30) / 64'd42;
         t  = one - ((x2 * t) >> 30) / 64'd20;
         t  = one - ((x2 * t) >> 30) / 64'd6;
         s  = (x * t) >> 30;
         r  = (s + (64'd1 << 14)) >> 15;
         if (r > 64'd32768) begin
            r = 64'd32768;
         end
         rom[k] = r[ROM_W-1:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

endpackage

// File: hw/rtl/sease_div.sv
// phase divider: saturates elapsed time to the duration and forms elapsed/duration in q0.16
// one quotient bit per stage; depends on sease_pkg
module sease_div
   import sease_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [ELAPSED_W-1:0] elapsed,
   input  logic [DUR_W-1:0]     duration,
   output beat_ctl_type         out_ctl,
   output logic [PHASE_W-1:0]   out_phase
);

   // entry stage: mask, zero duration as one, saturate
   beat_ctl_type     entry_ctl_ff, entry_ctl_in;
   logic [DUR_W-1:0] num_ff, num_in;
   logic [DUR_W-1:0] dvs_ff, dvs_in;
   logic [DUR_W-1:0] masked;

   always_comb begin
      masked       = elapsed & TIME_MASK;
      dvs_in       = (duration == '0) ? DUR_W'(1) : duration;
      entry_ctl_in = '{valid: in_valid, clamped: (masked > dvs_in)};
      num_in       = entry_ctl_in.clamped ? dvs_in : masked;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ctl_ff <= '0;
      end else if (en) begin
         entry_ctl_ff <= entry_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         dvs_ff <= dvs_in;
      end
   end

   // quotient pipeline, stage 0 holds the integer bit
   beat_ctl_type     ctl_ff [DIV_STEPS+1];
   logic [DUR_W-1:0] rem_ff [DIV_STEPS+1];
   logic [DUR_W-1:0] dv_ff  [DIV_STEPS+1];
   logic [PHASE_W-1:0] quo_ff [DIV_STEPS+1];

   logic             whole_in;
   assign whole_in = (num_ff == dvs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= entry_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= whole_in ? '0 : num_ff;
         dv_ff[0]  <= dvs_ff;
         quo_ff[0] <= whole_in ? PHASE_ONE : '0;
      end
   end

   // restoring steps, one fraction bit each
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [DUR_W:0]     trial;
      logic               take;
      logic [DUR_W-1:0]   rem_in;
      logic [PHASE_W-1:0] quo_in;

      always_comb begin
         trial  = {rem_ff[k-1], 1'b0};
         take   = (trial >= {1'b0, dv_ff[k-1]});
         rem_in = take ? DUR_W'(trial - {1'b0, dv_ff[k-1]}) : trial[DUR_W-1:0];
         quo_in = quo_ff[k-1];
         quo_in[DIV_STEPS-k] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (en) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            dv_ff[k]  <= dv_ff[k-1];
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign out_ctl   = ctl_ff[DIV_STEPS];
   assign out_phase = quo_ff[DIV_STEPS];

`ifndef SYNTHESIS
   a_clamp_full_phase: assert property (@(posedge clock) disable iff (reset)
      out_ctl.valid && out_ctl.clamped |-> out_phase == PHASE_ONE)
      else $error("clamped beat left the divider with a phase below one");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      out_ctl.valid |-> out_phase <= PHASE_ONE)
      else $error("divider phase above one");
`endif

endmodule

// File: hw/rtl/sease_curve.sv
// curve factor: maps the phase to a table angle, reads the sine table, forms the q0.16 factor
// four stages; depends on sease_pkg for widths, modes and the table
module sease_curve
   import sease_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  beat_ctl_type       in_ctl,
   input  logic [PHASE_W-1:0] phase,
   input  logic [MODE_W-1:0]  mode,
   output beat_ctl_type       out_ctl,
   output logic [PHASE_W-1:0] factor
);

   beat_ctl_type ctl_ff [4];
   logic [MODE_W-1:0] mode_ff [3];

   // control rides along all four stages, mode as far as the factor stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 4; s++) begin
            ctl_ff[s] <= '0;
         end
      end else if (en) begin
         ctl_ff[0] <= in_ctl;
         for (int s = 1; s < 4; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode_ff[0] <= mode;
         for (int s = 1; s < 3; s++) begin
            mode_ff[s] <= mode_ff[s-1];
         end
      end
   end

   // stage a: angle for the selected curve, rounded to a table index
   logic [ANGLE_W-1:0] angle;
   logic [ANGLE_W-1:0] angle_rnd;
   logic [IDX_W-1:0]   idx_ff;

   always_comb begin
      case (curve_mode_type'(mode))
         CURVE_IN:  angle = ANGLE_W'(phase);
         CURVE_OUT: angle = ANGLE_W'(phase) + ANGLE_QUARTER;
         default:   angle = {phase, 1'b0};
      endcase
      angle_rnd = angle + ANGLE_HALF_STEP;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff <= angle_rnd[ANGLE_W-1:ROM_SHIFT];
      end
   end

   // stage b: fold the index into the quarter wave, second quadrant is negative
   logic              neg_in;
   logic [ADDR_W-1:0] addr_in, addr_ff;
   logic              neg_b_ff, neg_c_ff;

   always_comb begin
      neg_in  = (idx_ff > IDX_W'(ROM_N));
      addr_in = neg_in ? ADDR_W'(idx_ff - IDX_W'(ROM_N)) : ADDR_W'(IDX_W'(ROM_N) - idx_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         addr_ff  <= addr_in;
         neg_b_ff <= neg_in;
      end
   end

   // stage c: table read
   logic [ROM_W-1:0] mag_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= SINE_ROM[addr_ff];
         neg_c_ff <= neg_b_ff;
      end
   end

   // stage d: cosine in q1.15, then the curve factor
   logic signed [FACT_S_W:0] cos_s;
   logic signed [FACT_S_W:0] fact_full;
   logic [PHASE_W-1:0]       factor_ff;

   always_comb begin
      cos_s = neg_c_ff ? -signed'((FACT_S_W + 1)'(mag_ff)) : signed'((FACT_S_W + 1)'(mag_ff));
      case (curve_mode_type'(mode_ff[2]))
         CURVE_IN:  fact_full = (signed'((FACT_S_W + 1)'(PHASE_ONE >> 1)) - cos_s) <<< 1;
         CURVE_OUT: fact_full = -(cos_s <<< 1);
         default:   fact_full = signed'((FACT_S_W + 1)'(PHASE_ONE >> 1)) - cos_s;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         factor_ff <= fact_full[PHASE_W-1:0];
      end
   end

   assign out_ctl = ctl_ff[3];
   assign factor  = factor_ff;

`ifndef SYNTHESIS
   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      out_ctl.valid |-> factor <= PHASE_ONE)
      else $error("curve factor above one");
`endif

endmodule

// File: hw/rtl/sease_scale.sv
// value scaling: change times factor, rounded half up, plus the start value
// two stages: multiply, then round and add; depends on sease_pkg
module sease_scale
   import sease_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  beat_ctl_type               in_ctl,
   input  logic [PHASE_W-1:0]         factor,
   input  logic signed [VAL_W-1:0]    change,
   input  logic signed [VAL_W-1:0]    start_value,
   output beat_ctl_type               out_ctl,
   output logic signed [RESULT_W-1:0] eased_value
);

   beat_ctl_type ctl_e_ff, ctl_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_e_ff <= '0;
         ctl_f_ff <= '0;
      end else if (en) begin
         ctl_e_ff <= in_ctl;
         ctl_f_ff <= ctl_e_ff;
      end
   end

   // stage e: signed product
   logic signed [FACT_S_W-1:0] fact_s;
   logic signed [PROD_W-1:0]   prod_in, prod_ff;

   assign fact_s  = signed'({1'b0, factor});
   assign prod_in = PROD_W'(change) * PROD_W'(fact_s);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   // stage f: floor((prod + half) / 2^16) + start
   logic signed [PROD_W-1:0]   biased;
   logic signed [SUM_W-1:0]    rounded;
   logic signed [SUM_W-1:0]    total;
   logic signed [RESULT_W-1:0] value_ff;

   always_comb begin
      biased  = prod_ff + signed'(PROD_W'(PHASE_ONE >> 1));
      rounded = biased[PROD_W-1:PHASE_FRAC];
      total   = rounded + SUM_W'(start_value);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= total[RESULT_W-1:0];
      end
   end

   assign out_ctl     = ctl_f_ff;
   assign eased_value = value_ff;

endmodule

// File: hw/rtl/sinusoidal_easing.sv
// an accepted request beat passes the phase divider, the curve and scale stages, then the response register
// throughput: one beat per cycle while the overflow slot is empty; the phase divider sets the depth
// a two-entry output buffer takes one more beat while a response waits, then stalls requests
// reset: synchronous, clears all valid bits and loads duration 1, start 0, change 0, ease in
// depends on sease_pkg, sease_div, sease_curve and sease_scale
module sinusoidal_easing
   import sease_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ELAPSED_W-1:0]       req_elapsed,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [RESULT_W-1:0] rsp_eased_value,
   output logic                       rsp_time_clamped
);

   // configuration registers
   logic [DUR_W-1:0]        duration_ff, duration_in;
   logic signed [VAL_W-1:0] start_value_ff, start_value_in;
   logic signed [VAL_W-1:0] change_ff, change_in;
   logic [MODE_W-1:0]       mode_ff, mode_in;

   always_comb begin
      duration_in    = duration_ff;
      start_value_in = start_value_ff;
      change_in      = change_ff;
      mode_in        = mode_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DURATION: duration_in    = csr_wr_data[DUR_W-1:0];
            CSR_START:    start_value_in = signed'(csr_wr_data[VAL_W-1:0]);
            CSR_CHANGE:   change_in      = signed'(csr_wr_data[VAL_W-1:0]);
            CSR_MODE:     mode_in        = csr_wr_data[MODE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff    <= DURATION_RESET;
         start_value_ff <= '0;
         change_ff      <= '0;
         mode_ff        <= CURVE_IN;
      end else begin
         duration_ff    <= duration_in;
         start_value_ff <= start_value_in;
         change_ff      <= change_in;
         mode_ff        <= mode_in;
      end
   end

   // pipeline advances whenever the overflow slot is empty
   logic pipe_en;
   logic skid_valid_ff, skid_valid_in;

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   beat_ctl_type       div_ctl, curve_ctl, scale_ctl;
   logic [PHASE_W-1:0] div_phase, curve_factor;
   logic signed [RESULT_W-1:0] scale_value;

   sease_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_valid),
      .elapsed   (req_elapsed),
      .duration  (duration_ff),
      .out_ctl   (div_ctl),
      .out_phase (div_phase)
   );

   sease_curve u_curve (
      .clock   (clock),
      .reset   (reset),
      .en      (pipe_en),
      .in_ctl  (div_ctl),
      .phase   (div_phase),
      .mode    (mode_ff),
      .out_ctl (curve_ctl),
      .factor  (curve_factor)
   );

   sease_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .en          (pipe_en),
      .in_ctl      (curve_ctl),
      .factor      (curve_factor),
      .change      (change_ff),
      .start_value (start_value_ff),
      .out_ctl     (scale_ctl),
      .eased_value (scale_value)
   );

   // response register and overflow slot
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_W-1:0] rsp_value_ff, rsp_value_in;
   logic                       rsp_clamp_ff, rsp_clamp_in;
   logic signed [RESULT_W-1:0] skid_value_ff, skid_value_in;
   logic                       skid_clamp_ff, skid_clamp_in;
   logic                       rsp_take;

   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_clamp_in  = rsp_clamp_ff;
      skid_valid_in = skid_valid_ff;
      skid_value_in = skid_value_ff;
      skid_clamp_in = skid_clamp_ff;
      if (skid_valid_ff) begin
         // pipeline frozen, drain the slot once the head beat leaves
         if (rsp_take) begin
            rsp_value_in  = skid_value_ff;
            rsp_clamp_in  = skid_clamp_ff;
            skid_valid_in = 1'b0;
         end
      end else if (scale_ctl.valid) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = scale_value;
            rsp_clamp_in = scale_ctl.clamped;
         end else begin
            skid_valid_in = 1'b1;
            skid_value_in = scale_value;
            skid_clamp_in = scale_ctl.clamped;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_clamp_ff  <= rsp_clamp_in;
      skid_value_ff <= skid_value_in;
      skid_clamp_ff <= skid_clamp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_eased_value  = rsp_value_ff;
   assign rsp_time_clamped = rsp_clamp_ff;

`ifndef SYNTHESIS
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("overflow slot holds a beat with no response beat ahead of it");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("overflow slot filled while the response beat was free to leave");
`endif

endmodule
